@@ design/stable_priority_job_queue_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the stable priority job queue
// shared property forms, all clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_JOB_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_JOB_QUEUE_ASSERT_SVH

// condition holds at every edge out of reset
`define SPJQ_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SPJQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPJQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/spjq_pkg.sv @@
// ----------------------------------------------------------------------------
// spjq_pkg
// types and constants shared by the priority job queue modules
// ----------------------------------------------------------------------------
package spjq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    localparam int unsigned ID_W       = 16;
    localparam int unsigned PRIO_W     = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned OCC_W      = 5;

    localparam int unsigned IN_FIELDS_W  = ID_W + PRIO_W;
    localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned IN_TUSER_W   = 1;
    localparam int unsigned OUT_FIELDS_W = ID_W + PRIO_W + OCC_W;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_READ,
        S_INS_CMP,
        S_INS_WRITE,
        S_REM_READ,
        S_REM_DATA,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;  // capture the incoming transaction
        logic rd_prev;    // read the slot below the insert hole
        logic rd_head;    // read the head slot
        logic wr_shift;   // move the read slot up into the hole
        logic wr_new;     // write the new job into the hole
        logic take_rem;   // keep the head entry as the result
        logic commit;     // update count and head, load the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        opcode_t in_op;        // opcode of the transaction on the input
        logic    cnt_zero;
        logic    cnt_full;
        logic    k_one;        // insert hole sits at slot one
        logic    prio_greater; // slot read last has a larger priority value
        logic    out_free;     // output register can take a result
    } sts_t;

endpackage

@@ design/spjq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spjq_ctrl
// sequencer for insert shifting, head removal and result hand-off
// ----------------------------------------------------------------------------
`include "stable_priority_job_queue_assert.svh"

module spjq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  spjq_pkg::sts_t sts,
    output spjq_pkg::cmd_t cmd
);
    import spjq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (sts.in_op == OP_REMOVE)
                    begin
                        state_next = sts.cnt_zero ? S_RESP : S_REM_READ;
                    end
                    else if (sts.cnt_full)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = sts.cnt_zero ? S_INS_WRITE : S_INS_READ;
                    end
                end
            end
            S_INS_READ:
            begin
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (!sts.prio_greater)
                begin
                    state_next = S_RESP;
                end
                else if (sts.k_one)
                begin
                    state_next = S_INS_WRITE;
                end
            end
            S_INS_WRITE:
            begin
                state_next = S_RESP;
            end
            S_REM_READ:
            begin
                state_next = S_REM_DATA;
            end
            S_REM_DATA:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            S_INS_READ:
            begin
                cmd.rd_prev = 1'b1;
            end
            S_INS_CMP:
            begin
                if (sts.prio_greater)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.rd_prev  = !sts.k_one;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                end
            end
            S_INS_WRITE:
            begin
                cmd.wr_new = 1'b1;
            end
            S_REM_READ:
            begin
                cmd.rd_head = 1'b1;
            end
            S_REM_DATA:
            begin
                cmd.take_rem = 1'b1;
            end
            S_RESP:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `SPJQ_ASSERT_NOW(a_one_write, !(cmd.wr_shift && cmd.wr_new), "two writes in one cycle")
    `SPJQ_ASSERT_NXT(a_last_shift, cmd.wr_shift && sts.k_one, state_reg == S_INS_WRITE, "shift to slot zero not followed by new job write")
    `SPJQ_ASSERT_NXT(a_commit_idle, cmd.commit, state_reg == S_IDLE && s_tready, "commit did not return to idle")

endmodule

@@ design/spjq_dp.sv @@
// ----------------------------------------------------------------------------
// spjq_dp
// slot memory as a ring, insert hole pointer, count and output register
// ----------------------------------------------------------------------------
`include "stable_priority_job_queue_assert.svh"

module spjq_dp
#(
    parameter int unsigned QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [spjq_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [spjq_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [spjq_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [spjq_pkg::STATUS_W-1:0]      m_tuser,
    input  spjq_pkg::cmd_t                     cmd,
    output spjq_pkg::sts_t                     sts
);
    import spjq_pkg::*;

    localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int unsigned MEM_DEPTH = 1 << PTR_W;
    localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);

    entry_t slot_mem [MEM_DEPTH];

    opcode_t          op_reg;
    entry_t           new_reg;
    entry_t           rd_data_reg;
    entry_t           res_reg;
    logic [PTR_W-1:0] k_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    entry_t           out_entry_reg;
    status_t          out_status_reg;
    logic [OCC_W-1:0] out_occ_reg;

    logic [PTR_W-1:0] rd_lidx;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             wr_en;
    logic             rd_en;
    logic             cnt_zero;
    logic             cnt_full;
    logic             ins_ok;
    logic             rem_ok;
    status_t          status_code;

    // ring addressing, logical slot zero sits at the head pointer
    assign rd_lidx = cmd.rd_head ? '0 : (k_reg - PTR_W'(1) - PTR_W'(cmd.wr_shift));
    assign rd_addr = head_reg + rd_lidx;
    assign wr_addr = head_reg + k_reg;
    assign wr_data = cmd.wr_new ? new_reg : rd_data_reg;
    assign wr_en   = cmd.wr_new | cmd.wr_shift;
    assign rd_en   = cmd.rd_prev | cmd.rd_head;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign cnt_zero = (cnt_reg == '0);
    assign cnt_full = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign ins_ok   = (op_reg == OP_INSERT) && !cnt_full;
    assign rem_ok   = (op_reg == OP_REMOVE) && !cnt_zero;

    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            status_code = cnt_full ? ST_FULL : ST_INSERTED;
        end
        else
        begin
            status_code = cnt_zero ? ST_EMPTY : ST_REMOVED;
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (cmd.commit && ins_ok)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.commit && rem_ok)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            head_next = head_reg + PTR_W'(1);
        end
    end

    assign out_valid_next = cmd.commit | (out_valid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload, hole pointer and result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg       <= opcode_t'(s_tuser[0]);
            new_reg.id   <= s_tdata[ID_W-1:0];
            new_reg.prio <= s_tdata[ID_W +: PRIO_W];
            res_reg      <= '0;
            k_reg        <= PTR_W'(cnt_reg);
        end
        else
        begin
            if (cmd.wr_shift)
            begin
                k_reg <= k_reg - PTR_W'(1);
            end
            if (cmd.take_rem)
            begin
                res_reg <= rd_data_reg;
            end
        end
        if (cmd.commit)
        begin
            out_entry_reg  <= res_reg;
            out_status_reg <= status_code;
            out_occ_reg    <= OCC_W'(cnt_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_occ_reg, out_entry_reg.prio, out_entry_reg.id});
    assign m_tuser  = out_status_reg;

    assign sts.in_op        = opcode_t'(s_tuser[0]);
    assign sts.cnt_zero     = cnt_zero;
    assign sts.cnt_full     = cnt_full;
    assign sts.k_one        = (k_reg == PTR_W'(1));
    assign sts.prio_greater = (rd_data_reg.prio > new_reg.prio);
    assign sts.out_free     = !out_valid_reg || m_tready;

    `SPJQ_ASSERT_NOW(a_cnt_bound, cnt_reg <= CNT_W'(QUEUE_DEPTH), "job count above queue depth")
    `SPJQ_ASSERT_NXT(a_ins_count, cmd.commit && ins_ok, cnt_reg == $past(cnt_reg) + 1'b1, "accepted insert did not raise count")
    `SPJQ_ASSERT_NXT(a_rem_head, cmd.commit && rem_ok, head_reg == $past(head_reg) + 1'b1, "removal did not advance head")

endmodule

@@ design/stable_priority_job_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_job_queue
// bounded job queue kept sorted by priority value, equal values leave in order
// ----------------------------------------------------------------------------
// Each input transaction is an insert (tuser 0) or a remove (tuser 1) and
// produces exactly one result transaction. Jobs sit in a slot memory with one
// read port and one write port, used as a ring, so the head slot always holds
// the job with the lowest priority value and a remove only advances the head
// pointer. An insert opens a hole at the tail and moves it toward the head one
// slot per cycle, shifting every stored job with a larger priority value up by
// one; the one read and one write per cycle set that pace. After the accepting
// cycle, an insert reads the slot below the hole, then compares and shifts until
// a job with no larger priority value is met or the hole reaches the head, and
// writes the new job into the hole (at once when the queue is empty); a remove
// reads the head slot and keeps its entry; an insert into a full queue or a
// remove from an empty one goes straight to the result. The result is loaded
// into the output register in the last step, and the next item can be accepted
// in the following cycle. The block handles one item at a time; a finished
// result waits in the output register and the block accepts the next item
// meanwhile, but that next item holds in its last cycle until the waiting result
// has been taken. Slots need no clearing after reset since only stored jobs are
// ever read. Occupancy reports the low 5 bits of the job count.
// ----------------------------------------------------------------------------
module stable_priority_job_queue
#(
    parameter int unsigned QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side, one job command per transaction
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spjq_pkg::IN_TDATA_W-1:0]   s_tdata,   // job_id[15:0], job_priority[23:16]
    input  logic [spjq_pkg::IN_TUSER_W-1:0]   s_tuser,   // opcode[0]
    // master side, one result per command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spjq_pkg::OUT_TDATA_W-1:0]  m_tdata,   // out_job_id[15:0], out_priority[23:16],
                                                         // occupancy[28:24], zero pad[31:29]
    output logic [spjq_pkg::STATUS_W-1:0]     m_tuser    // status[1:0]
);
    import spjq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: decides insert shifting, head read and result hand-off
    spjq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot memory, pointers, count and output register
    spjq_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
